[sv/fkvt_pkg.sv]
// Package for the flow key-value table: command and status codes.
// No dependencies.
`default_nettype none
package fkvt_pkg;
  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_GET    = 3'd1,
    CMD_SET    = 3'd2,
    CMD_ADD    = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } ctrl_t;
endpackage
`default_nettype wire

[sv/fkvt_if.sv]
// Valid/ready channel interfaces for requests and results.
// No dependencies.
`default_nettype none
interface fkvt_req_if #(parameter int KW = 64);
  logic          valid;
  logic          ready;
  logic [2:0]    cmd;
  logic [KW-1:0] match_key;
  logic [31:0]   value_in;
  modport source (output valid, cmd, match_key, value_in, input ready);
  modport sink (input valid, cmd, match_key, value_in, output ready);
endinterface

interface fkvt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value_out;
  modport source (output valid, status, value_out, input ready);
  modport sink (input valid, status, value_out, output ready);
endinterface
`default_nettype wire

[sv/fkvt_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fkvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

[sv/fkvt_datapath.sv]
// Datapath: hash, bucket row memory with valid bits, way compare and update.
// Depends on fkvt_pkg and fkvt_ram.
`default_nettype none
module fkvt_datapath #(
  parameter int BUCKET_BITS = 8,
  parameter int WAYS        = 4,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fkvt_pkg::ctrl_t      ctrl_i,
  input  wire logic [2:0]           cmd_i,
  input  wire logic [KEY_WIDTH-1:0] key_i,
  input  wire logic [31:0]          value_i,
  output logic [1:0]                status_o,
  output logic [31:0]               value_o,
  output logic                      clr_done_o
);
  localparam int BUCKETS = 1 << BUCKET_BITS;
  localparam int CHUNKS  = (KEY_WIDTH + BUCKET_BITS - 1) / BUCKET_BITS;
  localparam int PADW    = CHUNKS * BUCKET_BITS;
  localparam int SW      = KEY_WIDTH + VALUE_WIDTH;
  localparam int ROWW    = WAYS * SW + WAYS;
  localparam int WIW     = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [PADW-1:0]        key_pad;
  logic [BUCKET_BITS-1:0] hash;
  logic [BUCKET_BITS-1:0] bkt_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [2:0]             cmd_q;
  logic [BUCKET_BITS-1:0] clr_q;
  logic [WAYS-1:0]        rv;
  logic [ROWW-1:0]        row_rd;
  logic [ROWW-1:0]        row_wr;
  logic [WAYS-1:0]        vld_wr;
  logic [WAYS-1:0]        hit;
  logic                   found;
  logic [WIW-1:0]         hw;
  logic                   has_free;
  logic [WIW-1:0]         fw;
  logic                   we;
  logic [VALUE_WIDTH-1:0] hval;
  logic                   ram_we;
  logic [BUCKET_BITS-1:0] ram_waddr;
  logic [ROWW-1:0]        ram_wdata;

  always_comb begin
    key_pad = PADW'(key_i);
    hash    = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      hash ^= key_pad[c*BUCKET_BITS +: BUCKET_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      bkt_q <= hash;
      key_q <= key_i;
      val_q <= VALUE_WIDTH'(value_i);
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.clr_en) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign clr_done_o = (clr_q == '1);

  assign ram_we    = we || ctrl_i.clr_en;
  assign ram_waddr = ctrl_i.clr_en ? clr_q : bkt_q;
  assign ram_wdata = ctrl_i.clr_en ? '0 : row_wr;

  fkvt_ram #(.WIDTH(ROWW), .DEPTH(BUCKETS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (hash),
    .rdata_o (row_rd)
  );

  assign rv = row_rd[WAYS*SW +: WAYS];

  always_comb begin
    found    = 1'b0;
    hw       = '0;
    has_free = 1'b0;
    fw       = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit[w] = rv[w] && (row_rd[w*SW + VALUE_WIDTH +: KEY_WIDTH] == key_q);
      if (hit[w]) begin
        found = 1'b1;
        hw    = WIW'(w);
      end
      if (!rv[w]) begin
        has_free = 1'b1;
        fw       = WIW'(w);
      end
    end
    hval     = row_rd[hw*SW +: VALUE_WIDTH];
    row_wr   = row_rd;
    vld_wr   = rv;
    we       = 1'b0;
    status_o = fkvt_pkg::ST_MISS;
    value_o  = '0;
    unique case (cmd_q)
      fkvt_pkg::CMD_INSERT: begin
        if (has_free) begin
          row_wr[fw*SW +: SW] = {key_q, val_q};
          vld_wr[fw] = 1'b1;
          we         = 1'b1;
          status_o   = fkvt_pkg::ST_OK;
        end else begin
          status_o = fkvt_pkg::ST_FULL;
        end
      end
      fkvt_pkg::CMD_GET: begin
        if (found) begin
          status_o = fkvt_pkg::ST_OK;
          value_o  = 32'(hval);
        end
      end
      fkvt_pkg::CMD_SET: begin
        if (found) begin
          row_wr[hw*SW +: VALUE_WIDTH] = val_q;
          we       = 1'b1;
          status_o = fkvt_pkg::ST_OK;
        end
      end
      fkvt_pkg::CMD_ADD: begin
        if (found) begin
          row_wr[hw*SW +: VALUE_WIDTH] = hval + val_q;
          we       = 1'b1;
          status_o = fkvt_pkg::ST_OK;
        end
      end
      fkvt_pkg::CMD_REMOVE: begin
        if (found) begin
          for (int j = 0; j < WAYS - 1; j++) begin
            if (WIW'(j) >= hw) begin
              row_wr[j*SW +: SW] = row_rd[(j+1)*SW +: SW];
              vld_wr[j]          = rv[j+1];
            end
          end
          vld_wr[WAYS-1] = 1'b0;
          we       = 1'b1;
          status_o = fkvt_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
    row_wr[WAYS*SW +: WAYS] = vld_wr;
    we = we && ctrl_i.wr_en;
  end
endmodule
`default_nettype wire

[sv/fkvt_ctrl.sv]
// Controller: sequences clearing, read, update and result hand-off per transaction.
// Depends on fkvt_pkg.
`default_nettype none
module fkvt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire logic            clr_done_i,
  output fkvt_pkg::ctrl_t      ctrl_o
);
  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_OUT} state_e;
  state_e state_q, state_d;

  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    ctrl_o.rd_en  = in_valid_i && in_ready_o;
    ctrl_o.wr_en  = (state_q == S_EXEC);
    ctrl_o.clr_en = (state_q == S_CLEAR);
    state_d       = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_done_i) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_o <= (state_d == S_OUT);
    end
  end

`ifndef SYNTHESIS
  a_exec_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.wr_en |=> out_valid_o) else $error("exec not followed by result");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
`endif
endmodule
`default_nettype wire

[sv/flow_key_value_table.sv]
// Top level of the flow key-value table.
// Depends on fkvt_pkg, fkvt_if, fkvt_ctrl, fkvt_datapath, fkvt_ram.
//  channel | dir | payload
//  req     | in  | cmd, match_key, value_in
//  rsp     | out | status, value_out
// One transaction at a time, in order: accept and read the bucket row,
// compare and write back, then present the result until it is taken.
// After reset a clearing pass empties every bucket row, one per cycle, all
// 2^BUCKET_BITS rows (256 by default), before the first request is taken.
// A stalled result holds; no request is taken until it leaves.
`default_nettype none
module flow_key_value_table #(
  parameter int BUCKET_BITS = 8,
  parameter int WAYS        = 4,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fkvt_req_if.sink   req,
  fkvt_rsp_if.source rsp
);
  fkvt_pkg::ctrl_t ctrl;
  logic [1:0]      st;
  logic [31:0]     vo;
  logic            clr_done;

  fkvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .clr_done_i  (clr_done),
    .ctrl_o      (ctrl)
  );

  fkvt_datapath #(
    .BUCKET_BITS(BUCKET_BITS), .WAYS(WAYS),
    .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cmd_i      (req.cmd),
    .key_i      (req.match_key[KEY_WIDTH-1:0]),
    .value_i    (req.value_in),
    .status_o   (st),
    .value_o    (vo),
    .clr_done_o (clr_done)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.wr_en) begin
      rsp.status    <= st;
      rsp.value_out <= vo;
    end
  end
endmodule
`default_nettype wire
